### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off while reset is high.
`define MPM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication into the next cycle, off while reset is high.
`define MPM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Implication into the next cycle, live during reset as well.
`define MPM_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/mpm_pkg.sv
// Shared types and constants of the moment projection MAC core.
package mpm_pkg;

   localparam int MOMENTS_DEF    = 16;
   localparam int DIRECTIONS_DEF = 32;
   localparam int CELLS_DEF      = 1024;

   localparam int ACTION_W     = 2;
   localparam int MOMENT_IDX_W = 4;
   localparam int DIR_IDX_W    = 5;
   localparam int CELL_IDX_W   = 10;
   localparam int VALUE_W      = 32;
   localparam int ACC_W        = 48;
   localparam int PRODUCT_W    = 2 * VALUE_W;
   localparam int FRAC_W       = 16;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ACCUM = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ACCUM,
      OP_READ,
      OP_READ_ZERO
   } op_kind_type;

   typedef struct packed {
      op_kind_type                kind;
      logic [MOMENT_IDX_W-1:0]    moment;
      logic [DIR_IDX_W-1:0]       direction;
      logic [CELL_IDX_W-1:0]      cell_idx;
      logic signed [VALUE_W-1:0]  value;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_head_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

endpackage

### rtl/core/mpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mpm_front.sv
// Front end: accepts request items, checks indexes and queues operations.
module mpm_front import mpm_pkg::*; #(
   parameter int MOMENTS    = MOMENTS_DEF,
   parameter int DIRECTIONS = DIRECTIONS_DEF,
   parameter int CELLS      = CELLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACTION_W-1:0]   req_tuser,
   output queue_head_type        head,
   input  back_status_type       status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [MOMENT_IDX_W-1:0]   req_moment;
   logic [DIR_IDX_W-1:0]      req_direction;
   logic [CELL_IDX_W-1:0]     req_cell;
   logic signed [VALUE_W-1:0] req_value;
   logic                      moment_ok;
   logic                      direction_ok;
   logic                      cell_ok;
   logic                      keep;
   op_kind_type               kind;
   op_type                    push_op;
   logic                      push;

   op_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign req_moment    = req_tdata[3:0];
   assign req_direction = req_tdata[8:4];
   assign req_cell      = req_tdata[18:9];
   assign req_value     = $signed(req_tdata[50:19]);

   assign moment_ok    = 32'(req_moment) < MOMENTS;
   assign direction_ok = 32'(req_direction) < DIRECTIONS;
   assign cell_ok      = 32'(req_cell) < CELLS;

   // Out-of-range loads and samples are dropped here; out-of-range reads answer zero.
   always_comb begin
      keep = 1'b0;
      kind = OP_LOAD;
      case (req_tuser)
         ACT_LOAD: begin
            keep = moment_ok && direction_ok;
            kind = OP_LOAD;
         end
         ACT_ACCUM: begin
            keep = direction_ok && cell_ok;
            kind = OP_ACCUM;
         end
         ACT_READ: begin
            keep = 1'b1;
            kind = (moment_ok && cell_ok) ? OP_READ : OP_READ_ZERO;
         end
         default: begin
            keep = 1'b0;
            kind = OP_LOAD;
         end
      endcase
   end

   assign push_op = '{kind: kind, moment: req_moment, direction: req_direction,
                      cell_idx: req_cell, value: req_value};

   assign req_tready = !status.clearing && (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;

   assign wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = status.pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(status.pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.op    = entries_ff[rd_ptr_ff];

endmodule

### rtl/core/mpm_back.sv
// Back end: coefficient and moment memories, accumulate pipeline, result register.
module mpm_back import mpm_pkg::*; #(
   parameter int MOMENTS    = MOMENTS_DEF,
   parameter int DIRECTIONS = DIRECTIONS_DEF,
   parameter int CELLS      = CELLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_head_type        head,
   output back_status_type       status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]            rsp_tuser
);

   localparam int COEF_DEPTH = MOMENTS * DIRECTIONS;
   localparam int MOM_DEPTH  = MOMENTS * CELLS;
   localparam int CA_W       = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int MA_W       = (MOM_DEPTH > 1) ? $clog2(MOM_DEPTH) : 1;
   localparam int K_W        = (MOMENTS > 1) ? $clog2(MOMENTS) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC_RUN,
      ST_ACC_DRAIN,
      ST_READ_WAIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [MA_W-1:0]             clr_addr_ff, clr_addr_in;
   logic [K_W-1:0]              k_ff, k_in;
   logic [CA_W-1:0]             coef_addr_ff, coef_addr_in;
   logic [MA_W-1:0]             mom_addr_ff, mom_addr_in;
   logic signed [VALUE_W-1:0]   sample_ff, sample_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic [MA_W-1:0]             s1_addr_ff, s1_addr_in;
   logic                        s2_valid_ff, s2_valid_in;
   logic [MA_W-1:0]             s2_addr_ff, s2_addr_in;
   logic signed [PRODUCT_W-1:0] product_ff, product_in;
   logic signed [ACC_W-1:0]     old_ff, old_in;
   logic                        overflow_ff, overflow_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic                        pop;
   logic                        out_free;
   logic                        coef_wr_en;
   logic [CA_W-1:0]             coef_wr_addr;
   logic                        coef_rd_en;
   logic [VALUE_W-1:0]          coef_rd_data;
   logic                        mom_wr_en;
   logic [MA_W-1:0]             mom_wr_addr;
   logic [ACC_W-1:0]            mom_wr_data;
   logic                        mom_rd_en;
   logic [MA_W-1:0]             mom_rd_addr;
   logic [ACC_W-1:0]            mom_rd_data;

   logic signed [ACC_W-1:0]     term;
   logic signed [ACC_W:0]       sum_wide;
   logic                        saturate;
   logic signed [ACC_W-1:0]     sum_sat;

   mpm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (head.op.value),
      .rd_en   (coef_rd_en),
      .rd_addr (coef_addr_ff),
      .rd_data (coef_rd_data)
   );

   mpm_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MOM_DEPTH)
   ) u_moment_ram (
      .clock   (clock),
      .wr_en   (mom_wr_en),
      .wr_addr (mom_wr_addr),
      .wr_data (mom_wr_data),
      .rd_en   (mom_rd_en),
      .rd_addr (mom_rd_addr),
      .rd_data (mom_rd_data)
   );

   assign coef_wr_addr = CA_W'(32'(head.op.moment) * DIRECTIONS + 32'(head.op.direction));

   // Floor the Q32.32 product to Q32.16 and add with saturation.
   assign term     = product_ff[PRODUCT_W-1:FRAC_W];
   assign sum_wide = {old_ff[ACC_W-1], old_ff} + {term[ACC_W-1], term};
   assign saturate = sum_wide[ACC_W] != sum_wide[ACC_W-1];
   assign sum_sat  = !saturate ? sum_wide[ACC_W-1:0] : (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX);

   assign product_in = $signed(coef_rd_data) * sample_ff;
   assign old_in     = mom_rd_data;
   assign s2_valid_in = s1_valid_ff;
   assign s2_addr_in  = s1_addr_ff;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mom_wr_en   = 1'b1;
         mom_wr_addr = clr_addr_ff;
         mom_wr_data = '0;
      end else begin
         mom_wr_en   = s2_valid_ff;
         mom_wr_addr = s2_addr_ff;
         mom_wr_data = sum_sat;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      k_in         = k_ff;
      coef_addr_in = coef_addr_ff;
      mom_addr_in  = mom_addr_ff;
      sample_in    = sample_ff;
      s1_valid_in  = 1'b0;
      s1_addr_in   = mom_addr_ff;
      overflow_in  = overflow_ff || (s2_valid_ff && saturate);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      pop          = 1'b0;
      coef_wr_en   = 1'b0;
      coef_rd_en   = 1'b0;
      mom_rd_en    = 1'b0;
      mom_rd_addr  = mom_addr_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + MA_W'(1);
            if (clr_addr_ff == MA_W'(MOM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               case (head.op.kind)
                  OP_LOAD: begin
                     coef_wr_en = 1'b1;
                     pop        = 1'b1;
                  end
                  OP_ACCUM: begin
                     pop          = 1'b1;
                     coef_addr_in = CA_W'(head.op.direction);
                     mom_addr_in  = MA_W'(head.op.cell_idx);
                     sample_in    = head.op.value;
                     k_in         = '0;
                     state_in     = ST_ACC_RUN;
                  end
                  OP_READ: begin
                     if (out_free) begin
                        pop         = 1'b1;
                        mom_rd_en   = 1'b1;
                        mom_rd_addr = MA_W'(32'(head.op.moment) * CELLS +
                                            32'(head.op.cell_idx));
                        state_in    = ST_READ_WAIT;
                     end
                  end
                  OP_READ_ZERO: begin
                     if (out_free) begin
                        pop          = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                        rsp_ovf_in   = overflow_ff;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_ACC_RUN: begin
            // One moment per cycle; each moment has its own address, so no hazard.
            coef_rd_en   = 1'b1;
            mom_rd_en    = 1'b1;
            s1_valid_in  = 1'b1;
            coef_addr_in = coef_addr_ff + CA_W'(DIRECTIONS);
            mom_addr_in  = mom_addr_ff + MA_W'(CELLS);
            k_in         = k_ff + K_W'(1);
            if (k_ff == K_W'(MOMENTS - 1)) begin
               state_in = ST_ACC_DRAIN;
            end
         end
         ST_ACC_DRAIN: begin
            // Let the last writes land before the next item reads memory.
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = mom_rd_data;
            rsp_ovf_in   = overflow_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         k_ff         <= k_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      coef_addr_ff <= coef_addr_in;
      mom_addr_ff  <= mom_addr_in;
      sample_ff    <= sample_in;
      s1_addr_ff   <= s1_addr_in;
      s2_addr_ff   <= s2_addr_in;
      product_ff   <= product_in;
      old_ff       <= old_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign status.clearing = state_ff == ST_CLEAR;
   assign status.pop      = pop;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

endmodule

### rtl/core/moment_projection_mac_core.sv
// A read is answered through the moment memory's registered read and the response register;
// a load writes the coefficient memory from the queue head. A flux sample does one
// read-modify-write per moment through the moment memory port and its multiply and saturate stages.
// A 4-deep operation queue lets requests be accepted while a sample is in progress.
// Reset is synchronous; afterwards all MOMENTS * CELLS moment memory entries (16384 at the default)
// are cleared with req_tready low; coefficients are undefined until loaded.
module moment_projection_mac_core import mpm_pkg::*; #(
   parameter int MOMENTS    = MOMENTS_DEF,
   parameter int DIRECTIONS = DIRECTIONS_DEF,
   parameter int CELLS      = CELLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // moment_index[3:0], direction_index[8:4], cell_index[18:9], value[50:19], zero[55:51]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [ACTION_W-1:0]   req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // moment_value[47:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // overflow[0]
   output logic [0:0]            rsp_tuser
);

   queue_head_type  head;
   back_status_type status;

   mpm_front #(
      .MOMENTS    (MOMENTS),
      .DIRECTIONS (DIRECTIONS),
      .CELLS      (CELLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .status     (status)
   );

   mpm_back #(
      .MOMENTS    (MOMENTS),
      .DIRECTIONS (DIRECTIONS),
      .CELLS      (CELLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/core/mpm_checker.sv
// Port-level checker for the moment projection MAC core, bound to the top level.
`include "assert_macros.svh"

module mpm_checker import mpm_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [ACTION_W-1:0] req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [0:0]          rsp_tuser
);

   logic [3:0] pending_ff;
   logic [3:0] pending_in;
   logic       seen_ovf_ff;
   logic       seen_ovf_in;
   logic       read_accept;
   logic       rsp_accept;

   assign read_accept = req_tvalid && req_tready && (req_tuser == ACT_READ);
   assign rsp_accept  = rsp_tvalid && rsp_tready;
   assign pending_in  = pending_ff + 4'(read_accept) - 4'(rsp_accept);
   assign seen_ovf_in = seen_ovf_ff || (rsp_accept && rsp_tuser[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         seen_ovf_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         seen_ovf_ff <= seen_ovf_in;
      end
   end

   `MPM_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `MPM_ASSERT_IMP(a_rsp_has_read, clock, reset, rsp_tvalid, pending_ff != 4'd0)
   `MPM_ASSERT_IMP(a_ovf_sticky, clock, reset, rsp_tvalid && seen_ovf_ff, rsp_tuser[0])
   `MPM_ASSERT_NEXT_ALWAYS(a_clear_after_reset, clock, reset, !req_tready)

endmodule

bind moment_projection_mac_core mpm_checker u_mpm_checker (.*);
